@@ src/afg_pkg.sv @@
package afg_pkg;

    // field widths
    localparam int unsigned ANGLE_BITS     = 16;
    localparam int unsigned DATA_BITS      = 16;
    localparam int unsigned GAIN_BITS      = 16;
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CORDIC_STAGES  = 16;
    localparam int unsigned MAX_STAGES     = 32;

    // cordic datapath, q2.30
    localparam int unsigned CORDIC_BITS = 32;
    localparam int unsigned PHASE_SHIFT = CORDIC_BITS - ANGLE_BITS;
    localparam logic signed [CORDIC_BITS-1:0] CORDIC_X_INIT = 32'sh26DD3B6A;

    // atan(2^-i) as a fraction of a full turn of 2^32
    localparam logic signed [CORDIC_BITS-1:0] ATAN_TABLE [MAX_STAGES] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5,
        32'sd3,         32'sd1,         32'sd1,         32'sd0
    };

    // accumulation at 2^-42 scale
    localparam int unsigned SUM_BITS   = 57;
    localparam int unsigned ROUND_LSB  = 34;
    localparam int unsigned ROUND_BITS = SUM_BITS - ROUND_LSB;
    localparam int unsigned S_SHIFT    = 30;
    localparam int unsigned VA_SHIFT   = 22;
    localparam logic signed [SUM_BITS-1:0] ROUND_BIAS = SUM_BITS'(64'sd1 <<< (ROUND_LSB - 1));

    localparam logic signed [DATA_BITS-1:0] DRIVE_MAX = 16'sh7FFF;
    localparam logic signed [DATA_BITS-1:0] DRIVE_MIN = 16'sh8000;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_STATIC_GAIN   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRAVITY_GAIN  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VELOCITY_GAIN = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ACCEL_GAIN    = 2'd3;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] elevation_angle;
        logic signed [DATA_BITS-1:0]  angular_velocity;
        logic signed [DATA_BITS-1:0]  angular_accel;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] drive_value;
        logic                        saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [GAIN_BITS-1:0] static_gain;
        logic signed [GAIN_BITS-1:0] gravity_gain;
        logic signed [GAIN_BITS-1:0] velocity_gain;
        logic signed [GAIN_BITS-1:0] accel_gain;
    } t_gains;

    // what travels down the cordic chain
    typedef struct packed {
        logic signed [CORDIC_BITS-1:0] x;
        logic signed [CORDIC_BITS-1:0] y;
        logic signed [CORDIC_BITS-1:0] z;
        logic                          flip;
        logic signed [DATA_BITS-1:0]   vel;
        logic signed [DATA_BITS-1:0]   acc;
    } t_cell;

endpackage

@@ src/afg_cordic_cell.sv @@
module afg_cordic_cell
    import afg_pkg::*;
#(
    parameter int unsigned STAGE = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_cell i_data,
    input  logic  i_next_mv,
    output logic  o_mv,
    output logic  o_valid,
    output t_cell o_data
);

    logic  r_valid;
    t_cell r_data;
    t_cell n_data;
    logic signed [CORDIC_BITS-1:0] w_xs;
    logic signed [CORDIC_BITS-1:0] w_ys;

    // stage moves when empty or when its successor moves
    assign o_mv = !r_valid || i_next_mv;

    // one micro-rotation
    always_comb begin
        w_xs   = i_data.x >>> STAGE;
        w_ys   = i_data.y >>> STAGE;
        n_data = i_data;
        if (!i_data.z[CORDIC_BITS-1]) begin
            n_data.x = i_data.x - w_ys;
            n_data.y = i_data.y + w_xs;
            n_data.z = i_data.z - ATAN_TABLE[STAGE];
        end else begin
            n_data.x = i_data.x + w_ys;
            n_data.y = i_data.y - w_xs;
            n_data.z = i_data.z + ATAN_TABLE[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_mv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mv && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ src/afg_sum_tail.sv @@
module afg_sum_tail
    import afg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cell     i_data,
    input  t_gains    i_gains,
    output logic      o_mv,
    output logic      o_valid,
    output t_out_item o_out,
    input  logic      i_stall
);

    // product stage
    logic                            r_m_valid;
    logic signed [GAIN_BITS:0]       r_s_term;
    logic signed [GAIN_BITS+CORDIC_BITS-1:0] r_g_prod;
    logic signed [GAIN_BITS+DATA_BITS-1:0]   r_v_prod;
    logic signed [GAIN_BITS+DATA_BITS-1:0]   r_a_prod;
    logic signed [GAIN_BITS:0]       n_s_term;
    logic signed [GAIN_BITS+CORDIC_BITS-1:0] n_g_prod;
    logic signed [GAIN_BITS+DATA_BITS-1:0]   n_v_prod;
    logic signed [GAIN_BITS+DATA_BITS-1:0]   n_a_prod;
    logic signed [CORDIC_BITS-1:0]   w_cos;

    // partial sum stage
    logic                      r_s_valid;
    logic signed [SUM_BITS-1:0] r_sum_a;
    logic signed [SUM_BITS-1:0] r_sum_b;
    logic signed [SUM_BITS-1:0] n_sum_a;
    logic signed [SUM_BITS-1:0] n_sum_b;

    // output stage
    logic                        r_o_valid;
    t_out_item                   r_out;
    t_out_item                   n_out;
    logic signed [SUM_BITS-1:0]  w_total;
    logic [ROUND_BITS-1:0]       w_round;
    logic                        w_over;

    logic w_mv_s;
    logic w_mv_o;

    // backpressure through the three stages
    assign w_mv_o = !r_o_valid || !i_stall;
    assign w_mv_s = !r_s_valid || w_mv_o;
    assign o_mv   = !r_m_valid || w_mv_s;

    // undo the half-turn fold, then form the three products and the static term
    always_comb begin
        w_cos    = i_data.flip ? -i_data.x : i_data.x;
        n_g_prod = i_gains.gravity_gain * w_cos;
        n_v_prod = i_gains.velocity_gain * i_data.vel;
        n_a_prod = i_gains.accel_gain * i_data.acc;
        if (i_data.vel == '0) begin
            n_s_term = '0;
        end else if (i_data.vel[DATA_BITS-1]) begin
            n_s_term = -(GAIN_BITS+1)'(i_gains.static_gain);
        end else begin
            n_s_term = (GAIN_BITS+1)'(i_gains.static_gain);
        end
    end

    // align to the common scale and add in pairs
    always_comb begin
        n_sum_a = (SUM_BITS'(r_s_term) <<< S_SHIFT) + SUM_BITS'(r_g_prod);
        n_sum_b = (SUM_BITS'(r_v_prod) <<< VA_SHIFT) + (SUM_BITS'(r_a_prod) <<< VA_SHIFT);
    end

    // final add, round half up, clip to q8.8
    always_comb begin
        w_total = r_sum_a + r_sum_b + ROUND_BIAS;
        w_round = w_total[SUM_BITS-1:ROUND_LSB];
        w_over  = (w_round[ROUND_BITS-1:DATA_BITS-1] != '0) &&
                  (w_round[ROUND_BITS-1:DATA_BITS-1] != '1);
        n_out.saturated = w_over;
        if (w_over) begin
            n_out.drive_value = w_round[ROUND_BITS-1] ? DRIVE_MIN : DRIVE_MAX;
        end else begin
            n_out.drive_value = w_round[DATA_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_mv) begin
                r_m_valid <= i_valid;
            end
            if (w_mv_s) begin
                r_s_valid <= r_m_valid;
            end
            if (w_mv_o) begin
                r_o_valid <= r_s_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mv && i_valid) begin
            r_s_term <= n_s_term;
            r_g_prod <= n_g_prod;
            r_v_prod <= n_v_prod;
            r_a_prod <= n_a_prod;
        end
        if (w_mv_s && r_m_valid) begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
        if (w_mv_o && r_s_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_o_valid;
    assign o_out   = r_out;

endmodule

@@ src/arm_gravity_feedforward.sv @@
// Arm feedforward drive: for each input transfer the block returns one result,
// kS*sign(velocity) + kG*cos(angle) + kV*velocity + kA*acceleration, rounded
// half up to signed Q8.8 and clipped, with saturated set when clipping occurred.
// The cosine comes from a chain of CORDIC_STAGES rotation cells, one register
// each, followed by a product stage, a partial-sum stage and the output
// register; one item is taken every cycle while o_stall is low. Stages with
// no item close up, so input transfers continue while a result waits under
// i_stall backpressure until the chain is full. Gains are Q4.12; the user must
// write them through the plain write port only while the block is idle, which
// the block itself does not enforce. They reset to zero.
module arm_gravity_feedforward
    import afg_pkg::*;
#(
    parameter int unsigned CORDIC_STAGES = afg_pkg::CORDIC_STAGES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_in_item                  i_in,
    output logic                      o_stall,
    output logic                      o_valid,
    output t_out_item                 o_out,
    input  logic                      i_stall,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [GAIN_BITS-1:0]      i_cfg_data
);

    t_gains r_gains;

    t_cell w_data  [CORDIC_STAGES+1];
    logic  w_valid [CORDIC_STAGES+1];
    logic  w_mv    [CORDIC_STAGES+1];

    logic [CORDIC_BITS-1:0] w_phase;
    logic                   w_flip;

    // gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_STATIC_GAIN:   r_gains.static_gain   <= i_cfg_data;
                REG_GRAVITY_GAIN:  r_gains.gravity_gain  <= i_cfg_data;
                REG_VELOCITY_GAIN: r_gains.velocity_gain <= i_cfg_data;
                REG_ACCEL_GAIN:    r_gains.accel_gain    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // widen the angle to a full-turn phase and fold it into +-pi/2
    always_comb begin
        w_phase         = CORDIC_BITS'(unsigned'(i_in.elevation_angle)) << PHASE_SHIFT;
        w_flip          = w_phase[CORDIC_BITS-1] ^ w_phase[CORDIC_BITS-2];
        w_data[0].x     = CORDIC_X_INIT;
        w_data[0].y     = '0;
        w_data[0].z     = {w_phase[CORDIC_BITS-1] ^ w_flip, w_phase[CORDIC_BITS-2:0]};
        w_data[0].flip  = w_flip;
        w_data[0].vel   = i_in.angular_velocity;
        w_data[0].acc   = i_in.angular_accel;
    end

    assign w_valid[0] = i_valid;
    assign o_stall    = !w_mv[0];

    // rotation cells
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        afg_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (w_valid[g]),
            .i_data    (w_data[g]),
            .i_next_mv (w_mv[g+1]),
            .o_mv      (w_mv[g]),
            .o_valid   (w_valid[g+1]),
            .o_data    (w_data[g+1])
        );
    end

    // products, sum, rounding and output register
    afg_sum_tail u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[CORDIC_STAGES]),
        .i_data  (w_data[CORDIC_STAGES]),
        .i_gains (r_gains),
        .o_mv    (w_mv[CORDIC_STAGES]),
        .o_valid (o_valid),
        .o_out   (o_out),
        .i_stall (i_stall)
    );

endmodule

@@ src/afg_checker.sv @@
module afg_checker
    import afg_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_stall,
    input logic      o_valid,
    input t_out_item o_out,
    input logic      i_stall
);

    // no result right after a reset cycle
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a clipped result sits at a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.saturated) |->
            (o_out.drive_value == DRIVE_MAX || o_out.drive_value == DRIVE_MIN))
        else $error("saturated flag without rail value");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped under stall");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_out))
        else $error("result changed under stall");

    // input stalls only when a result is held off at the output
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with output free");

endmodule

bind arm_gravity_feedforward afg_checker u_afg_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_out   (o_out),
    .i_stall (i_stall)
);
